/* hdl/tlv_stream_parser_core_defines.svh */
// ----------------------------------------------------------------------------
// tlv_stream_parser_core_defines.svh
// Assertion macros shared by the TLV stream parser RTL.
// ----------------------------------------------------------------------------
`ifndef TLV_STREAM_PARSER_CORE_DEFINES_SVH
`define TLV_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TLVSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TLVSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tlvsp_pkg.sv */
// ----------------------------------------------------------------------------
// tlvsp_pkg
// Types, constants and helpers for the TLV stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlvsp_pkg;

    // type (2 bytes) + length (2 bytes)
    localparam int unsigned HEADER_BYTES = 4;

    // APB register map
    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0]  REG_MAX_RECORDS = 1'b0;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_VALUE   = 2'd1,
        PH_STOPPED = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_CONSUMED     = 2'd0,
        ST_SHORT_HEADER = 2'd1,
        ST_INCOMPLETE   = 2'd2,
        ST_LIMIT        = 2'd3
    } t_end_status;

    typedef struct packed {
        logic        record_valid;
        logic [15:0] record_type;
        logic [15:0] record_length;
        logic [31:0] record_number;
        logic [15:0] value_offset;
        logic [15:0] record_index;
        logic        buffer_done;
        t_end_status end_status;
    } t_result;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // numeric value is reported for 1, 2 and 4 byte values only
    function automatic logic is_number_len(input logic [15:0] len);
        return (len == 16'd1) || (len == 16'd2) || (len == 16'd4);
    endfunction

endpackage

`default_nettype wire

/* hdl/tlvsp_in_if.sv */
// ----------------------------------------------------------------------------
// tlvsp_in_if
// Byte input channel: one buffer byte per word, last byte marked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tlvsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

/* hdl/tlvsp_out_if.sv */
// ----------------------------------------------------------------------------
// tlvsp_out_if
// Result channel: one record report and/or end-of-buffer status per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tlvsp_out_if;
    logic        valid;
    logic        ready;
    logic        record_valid;
    logic [15:0] record_type;
    logic [15:0] record_length;
    logic [31:0] record_number;
    logic [15:0] value_offset;
    logic [15:0] record_index;
    logic        buffer_done;
    logic [1:0]  end_status;

    modport source (
        output valid, output record_valid, output record_type, output record_length,
        output record_number, output value_offset, output record_index,
        output buffer_done, output end_status, input ready
    );
    modport sink (
        input valid, input record_valid, input record_type, input record_length,
        input record_number, input value_offset, input record_index,
        input buffer_done, input end_status, output ready
    );
endinterface

`default_nettype wire

/* hdl/tlvsp_out_skid.sv */
// ----------------------------------------------------------------------------
// tlvsp_out_skid
// Output register plus skid register; upstream ready is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlvsp_out_skid (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  tlvsp_pkg::t_result i_data,
    output logic               o_can_push,
    output logic               o_valid,
    output tlvsp_pkg::t_result o_data,
    input  wire                i_ready
);

    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    tlvsp_pkg::t_result r_out, n_out;
    tlvsp_pkg::t_result r_skid, n_skid;
    logic               pop;

    assign pop        = r_out_valid && i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (pop) begin
            n_out_valid = 1'b0;
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end
        // push only happens with the skid empty
        if (i_push) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

/* hdl/tlv_stream_parser_core.sv */
// ----------------------------------------------------------------------------
// tlv_stream_parser_core
// A result word is registered in the output register, or in the skid register while the output one is occupied.
// Throughput: one byte per cycle while ready is high; the byte path has one register stage of logic.
// Ready drops only when both output and skid registers hold undelivered words.
// Reset (sync, active low) clears parse state, max_records and both output stages.
// Parses 16-bit BE type, 16-bit BE length, then value bytes; reports each record up to the record limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tlv_stream_parser_core_defines.svh"

module tlv_stream_parser_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    tlvsp_in_if.sink                           i_byte_if,
    tlvsp_out_if.source                        o_rec_if,
    // APB-style configuration port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [tlvsp_pkg::PADDR_W-1:0]      paddr,
    input  wire  [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [15:0] r_max_records;
    logic        cfg_wr;
    logic        sel_max;

    assign pready  = 1'b1;
    assign sel_max = (paddr[2] == tlvsp_pkg::REG_MAX_RECORDS);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = 32'd0;
        if (sel_max) begin
            prdata = {16'd0, r_max_records};
        end
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    tlvsp_pkg::t_phase r_phase, n_phase;
    logic [31:0]       r_header_shift, n_header_shift;      // type in [31:16], length in [15:0]
    logic [15:0]       r_field_byte_count, n_field_byte_count;
    logic [31:0]       r_value_accumulator, n_value_accumulator;
    logic [15:0]       r_byte_offset, n_byte_offset;        // offset of the next byte, sticky at max
    logic [15:0]       r_records_seen, n_records_seen;
    logic [15:0]       r_value_start, n_value_start;

    logic               accept;
    logic               push;
    logic               can_push;
    logic               rec_complete;
    logic [15:0]        rec_len;
    tlvsp_pkg::t_result res;
    tlvsp_pkg::t_result out_word;

    assign i_byte_if.ready = can_push;
    assign accept          = i_byte_if.valid && i_byte_if.ready;
    // a word goes out when a record closes or the buffer ends
    assign push            = accept && (rec_complete || i_byte_if.end_of_buffer);

    // ------------------------------------------------------------------
    // One byte step: next state and result word
    // ------------------------------------------------------------------
    always_comb begin
        n_phase             = r_phase;
        n_header_shift      = r_header_shift;
        n_field_byte_count  = r_field_byte_count;
        n_value_accumulator = r_value_accumulator;
        n_byte_offset       = r_byte_offset;
        n_records_seen      = r_records_seen;
        n_value_start       = r_value_start;
        rec_len             = r_header_shift[15:0];
        rec_complete        = 1'b0;
        res                 = '0;

        unique case (r_phase)
            tlvsp_pkg::PH_HEADER: begin
                n_header_shift = {r_header_shift[23:0], i_byte_if.data_byte};
                if (r_field_byte_count == 16'(tlvsp_pkg::HEADER_BYTES - 1)) begin
                    // header complete: value starts after this byte
                    n_field_byte_count  = 16'd0;
                    n_value_accumulator = 32'd0;
                    n_value_start       = tlvsp_pkg::sat_inc16(r_byte_offset);
                    rec_len             = n_header_shift[15:0];
                    if (rec_len == 16'd0) begin
                        rec_complete = 1'b1;   // empty value closes at once
                    end else begin
                        n_phase = tlvsp_pkg::PH_VALUE;
                    end
                end else begin
                    n_field_byte_count = r_field_byte_count + 16'd1;
                end
            end
            tlvsp_pkg::PH_VALUE: begin
                n_value_accumulator = {r_value_accumulator[23:0], i_byte_if.data_byte};
                n_field_byte_count  = r_field_byte_count + 16'd1;
                if (n_field_byte_count == rec_len) begin
                    rec_complete = 1'b1;
                end
            end
            default: begin
                // stopped by the record limit: bytes only advance the offset
            end
        endcase

        if (rec_complete) begin
            res.record_type   = n_header_shift[31:16];
            res.record_length = rec_len;
            res.record_number = tlvsp_pkg::is_number_len(rec_len) ? n_value_accumulator : 32'd0;
            res.value_offset  = n_value_start;
            res.record_index  = r_records_seen;
            n_records_seen      = r_records_seen + 16'd1;
            n_field_byte_count  = 16'd0;
            n_value_accumulator = 32'd0;
            // limit hits only on an exact match with the count
            if ((r_max_records != 16'd0) && (n_records_seen == r_max_records)) begin
                n_phase = tlvsp_pkg::PH_STOPPED;
            end else begin
                n_phase = tlvsp_pkg::PH_HEADER;
            end
        end
        res.record_valid = rec_complete;

        n_byte_offset = tlvsp_pkg::sat_inc16(r_byte_offset);

        if (i_byte_if.end_of_buffer) begin
            res.buffer_done = 1'b1;
            priority if (n_phase == tlvsp_pkg::PH_STOPPED) begin
                res.end_status = tlvsp_pkg::ST_LIMIT;
            end else if (n_phase == tlvsp_pkg::PH_VALUE) begin
                res.end_status = tlvsp_pkg::ST_INCOMPLETE;
            end else if (n_field_byte_count != 16'd0) begin
                res.end_status = tlvsp_pkg::ST_SHORT_HEADER;
            end else begin
                res.end_status = tlvsp_pkg::ST_CONSUMED;
            end
            // fresh state for the next buffer
            n_phase             = tlvsp_pkg::PH_HEADER;
            n_header_shift      = 32'd0;
            n_field_byte_count  = 16'd0;
            n_value_accumulator = 32'd0;
            n_byte_offset       = 16'd0;
            n_records_seen      = 16'd0;
            n_value_start       = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_records       <= 16'd0;
            r_phase             <= tlvsp_pkg::PH_HEADER;
            r_header_shift      <= 32'd0;
            r_field_byte_count  <= 16'd0;
            r_value_accumulator <= 32'd0;
            r_byte_offset       <= 16'd0;
            r_records_seen      <= 16'd0;
            r_value_start       <= 16'd0;
        end else begin
            if (cfg_wr && sel_max) begin
                r_max_records <= pwdata[15:0];
            end
            if (accept) begin
                r_phase             <= n_phase;
                r_header_shift      <= n_header_shift;
                r_field_byte_count  <= n_field_byte_count;
                r_value_accumulator <= n_value_accumulator;
                r_byte_offset       <= n_byte_offset;
                r_records_seen      <= n_records_seen;
                r_value_start       <= n_value_start;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register + skid
    // ------------------------------------------------------------------
    tlvsp_out_skid u_out_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (res),
        .o_can_push (can_push),
        .o_valid    (o_rec_if.valid),
        .o_data     (out_word),
        .i_ready    (o_rec_if.ready)
    );

    assign o_rec_if.record_valid  = out_word.record_valid;
    assign o_rec_if.record_type   = out_word.record_type;
    assign o_rec_if.record_length = out_word.record_length;
    assign o_rec_if.record_number = out_word.record_number;
    assign o_rec_if.value_offset  = out_word.value_offset;
    assign o_rec_if.record_index  = out_word.record_index;
    assign o_rec_if.buffer_done   = out_word.buffer_done;
    assign o_rec_if.end_status    = out_word.end_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TLVSP_ASSERT_NOW(a_hdr_count_bound, i_clk, i_rst_n,
        r_phase == tlvsp_pkg::PH_HEADER,
        r_field_byte_count < 16'(tlvsp_pkg::HEADER_BYTES),
        "header byte count out of range")
    `TLVSP_ASSERT_NOW(a_value_count_bound, i_clk, i_rst_n,
        r_phase == tlvsp_pkg::PH_VALUE,
        r_field_byte_count < r_header_shift[15:0],
        "value byte count reached length without closing record")
    `TLVSP_ASSERT_NEXT(a_eob_clears, i_clk, i_rst_n,
        accept && i_byte_if.end_of_buffer,
        (r_phase == tlvsp_pkg::PH_HEADER) && (r_byte_offset == 16'd0)
            && (r_records_seen == 16'd0) && (r_field_byte_count == 16'd0),
        "parse state not cleared after last buffer byte")
    `TLVSP_ASSERT_NOW(a_stall_has_word, i_clk, i_rst_n,
        !i_byte_if.ready,
        o_rec_if.valid,
        "input stalled with no output word pending")

endmodule

`default_nettype wire
